### hw/rtl/programmable_fsm_with_reachability_core_defines.svh
// Assertion macros shared by the RTL of the programmable state machine core.
`ifndef PROGRAMMABLE_FSM_WITH_REACHABILITY_CORE_DEFINES_SVH
`define PROGRAMMABLE_FSM_WITH_REACHABILITY_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked after reset is released.
`define PFSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define PFSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PFSM_ASSERT(lbl, prop, msg)
`define PFSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/pfsm_pkg.sv
// Shared types, codes and constants of the programmable state machine core.
package pfsm_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int MASK_W    = 8;

    typedef enum logic [2:0] {
        ACT_STEP    = 3'd0,
        ACT_REWRITE = 3'd1,
        ACT_FIND    = 3'd2,
        ACT_PURGE   = 3'd3,
        ACT_QUERY   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_REACH,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;     // capture the incoming request
        logic seed;     // start a reachability sweep from the current state
        logic iterate;  // one propagation step of the sweep
        logic commit;   // update state and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_find;
        logic out_free;
    } ctrl_sts_t;

    // Initial transition table: states 0..7 fixed, higher states loop to themselves.
    function automatic logic [3:0] init_next(input logic [3:0] s, input logic b);
        logic [3:0] v;
        case (s)
            4'd0: v = b ? 4'd6 : 4'd7;
            4'd1: v = b ? 4'd7 : 4'd4;
            4'd2: v = b ? 4'd3 : 4'd5;
            4'd3: v = b ? 4'd4 : 4'd1;
            4'd4: v = b ? 4'd5 : 4'd6;
            4'd5: v = b ? 4'd0 : 4'd3;
            4'd6: v = b ? 4'd1 : 4'd0;
            4'd7: v = b ? 4'd2 : 4'd7;
            default: v = s;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/programmable_fsm_with_reachability_core.sv
// Top level of the programmable state machine core with reachability tracking.
// Usage: one request per s_ handshake (action, edge_bit, target), one result per
// request on the m_ channel, in order. Step follows an edge of the current state,
// rewrite redirects one, find garbage sweeps reachability, purge deletes listed
// targets, query reports a listed state.
// Sequence: step, rewrite, purge and query pass through decode and execute;
// find garbage runs the propagation steps of the sweep over the transition
// table, then done. A result is loaded once the output register is free; the
// next request is accepted in idle after that, while the result may still wait
// in the output register. The sequencer handles one request at a time.
// Reset (aresetn low, synchronous) restores the initial transition table, state
// A, and clears all masks. Send no request in reset; the core does not block it.
// If the receiver holds m_tready low, the result stays put and at most one more
// request is accepted; it finishes and then waits for the output register.
module programmable_fsm_with_reachability_core #(
    parameter int NUM_STATES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action[2:0], edge_bit[3], target[6:4], zero[7]
    input  logic [pfsm_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // current_state[2:0], reachable_mask[10:3], garbage_mask[18:11],
    // listed_mask[26:19], deleted_flags[34:27], ok[35], zero[39:36]
    output logic [pfsm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import pfsm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pfsm_ctrl #(
        .NUM_STATES (NUM_STATES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfsm_datapath #(
        .NUM_STATES (NUM_STATES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

### hw/rtl/pfsm_ctrl.sv
// Sequencer for the state machine core: request intake, sweep count, commit.
`include "programmable_fsm_with_reachability_core_defines.svh"

module pfsm_ctrl #(
    parameter int NUM_STATES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfsm_pkg::ctrl_sts_t  sts,
    output pfsm_pkg::ctrl_cmd_t  cmd
);
    import pfsm_pkg::*;

    localparam int CW = $clog2(NUM_STATES);

    ctrl_state_t   state_reg, state_next;
    logic [CW-1:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_find) begin
                    cmd.seed   = 1'b1;
                    iter_next  = '0;
                    state_next = ST_REACH;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC, ST_DONE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REACH: begin
                cmd.iterate = 1'b1;
                if (iter_reg == CW'(NUM_STATES - 1)) begin
                    iter_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PFSM_ASSERT(a_commit_needs_slot, cmd.commit |-> sts.out_free, "commit while result pending")
    `PFSM_ASSERT(a_accept_decodes, (in_valid && in_ready) |=> (state_reg == ST_DECODE),
        "accepted request not decoded")
    `PFSM_ASSERT(a_sweep_ends_in_done, (state_reg == ST_DONE) |-> ($past(cmd.iterate) || $past(state_reg == ST_DONE)),
        "result of sweep committed without propagation")
endmodule

### hw/rtl/pfsm_datapath.sv
// Transition table, current state, masks, reachability sweep and result register.
`include "programmable_fsm_with_reachability_core_defines.svh"

module pfsm_datapath #(
    parameter int NUM_STATES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pfsm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  pfsm_pkg::ctrl_cmd_t               cmd,
    output pfsm_pkg::ctrl_sts_t               sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfsm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import pfsm_pkg::*;

    localparam int SW = $clog2(NUM_STATES);
    localparam int MW = (NUM_STATES > MASK_W) ? NUM_STATES : MASK_W;

    function automatic logic [2*NUM_STATES*SW-1:0] reset_table();
        logic [2*NUM_STATES*SW-1:0] v;
        v = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            for (int b = 0; b < 2; b++) begin
                v[(2*s+b)*SW +: SW] = SW'(init_next(4'(s), 1'(b)) % NUM_STATES);
            end
        end
        return v;
    endfunction

    localparam logic [2*NUM_STATES*SW-1:0] RESET_TBL = reset_table();

    // request register
    logic [2:0] act_reg;
    logic       edge_reg;
    logic [2:0] tgt_reg;

    logic [SW-1:0]         tbl_reg [NUM_STATES][2];
    logic [SW-1:0]         cur_reg, cur_next;
    logic [NUM_STATES-1:0] reach_reg, reach_next;
    logic [NUM_STATES-1:0] listed_reg, listed_next;
    logic [NUM_STATES-1:0] del_reg, del_next;
    logic [NUM_STATES-1:0] sweep_reg, sweep_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [NUM_STATES-1:0] succ, targets, garbage, newly, garbage_out;
    logic [MW-1:0]         del_ext, listed_ext;
    logic [MW-1:0]         cur_ext, reach_ext, garb_ext, listed_o_ext, del_o_ext;
    logic                  tgt_ok, tbl_we, ok;
    logic [SW-1:0]         tgt_idx;

    assign sts.is_find  = (act_reg == ACT_FIND);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_tdata[2:0];
            edge_reg <= s_tdata[3];
            tgt_reg  <= s_tdata[6:4];
        end
    end

    always_comb begin
        succ    = '0;
        targets = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            targets = targets | (NUM_STATES'(1) << tbl_reg[s][0])
                              | (NUM_STATES'(1) << tbl_reg[s][1]);
            if (sweep_reg[s]) begin
                succ = succ | (NUM_STATES'(1) << tbl_reg[s][0])
                            | (NUM_STATES'(1) << tbl_reg[s][1]);
            end
        end
    end

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.seed) begin
            sweep_next = del_reg[cur_reg] ? '0 : (NUM_STATES'(1) << cur_reg);
        end else if (cmd.iterate) begin
            sweep_next = sweep_reg | (succ & ~del_reg);
        end
    end

    always_ff @(posedge aclk) begin
        sweep_reg <= sweep_next;
    end

    assign del_ext    = MW'(del_reg);
    assign listed_ext = MW'(listed_reg);
    assign tgt_ok     = (int'(tgt_reg) < NUM_STATES);
    assign tgt_idx    = SW'(tgt_reg);
    assign garbage    = ~sweep_reg & ~del_reg;
    assign newly      = targets & listed_reg & ~del_reg;

    always_comb begin
        cur_next    = cur_reg;
        reach_next  = reach_reg;
        listed_next = listed_reg;
        del_next    = del_reg;
        garbage_out = '0;
        ok          = 1'b0;
        tbl_we      = 1'b0;
        case (act_reg)
            ACT_STEP: cur_next = tbl_reg[cur_reg][edge_reg];
            ACT_REWRITE: begin
                if (tgt_ok && !del_ext[tgt_reg]) begin
                    tbl_we = 1'b1;
                    ok     = 1'b1;
                end
            end
            ACT_FIND: begin
                reach_next  = sweep_reg;
                garbage_out = garbage;
                listed_next = listed_reg | garbage;
            end
            ACT_PURGE: begin
                del_next = del_reg | newly;
                ok       = |newly;
            end
            ACT_QUERY: ok = tgt_ok && listed_ext[tgt_reg];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_STATES; s++) begin
                for (int b = 0; b < 2; b++) begin
                    tbl_reg[s][b] <= RESET_TBL[(2*s+b)*SW +: SW];
                end
            end
            cur_reg    <= '0;
            reach_reg  <= '0;
            listed_reg <= '0;
            del_reg    <= '0;
        end else if (cmd.commit) begin
            if (tbl_we) begin
                tbl_reg[cur_reg][edge_reg] <= tgt_idx;
            end
            cur_reg    <= cur_next;
            reach_reg  <= reach_next;
            listed_reg <= listed_next;
            del_reg    <= del_next;
        end
    end

    assign cur_ext      = MW'(cur_next);
    assign reach_ext    = MW'(reach_next);
    assign garb_ext     = MW'(garbage_out);
    assign listed_o_ext = MW'(listed_next);
    assign del_o_ext    = MW'(del_next);

    assign m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {4'b0000, ok, del_o_ext[MASK_W-1:0], listed_o_ext[MASK_W-1:0],
                            garb_ext[MASK_W-1:0], reach_ext[MASK_W-1:0], cur_ext[2:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PFSM_ASSERT(a_deleted_were_listed, (del_reg & ~listed_reg) == '0,
        "deleted state never listed")
    `PFSM_ASSERT(a_commit_shows_result, cmd.commit |=> m_tvalid_reg,
        "commit did not raise result valid")
    `PFSM_ASSERT(a_current_in_range, int'(cur_reg) < NUM_STATES,
        "current state out of range")
endmodule

### tb/tb.sv
// Self-checking testbench for the programmable state machine core with reachability tracking.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfsm_pkg::*;

    localparam int NSTATES    = 8;
    localparam int RAND_REQS  = 1530;
    localparam int MAX_CYCLES = 1000000;
    localparam int TAIL_WAIT  = 40;

    // action codes the core does not decode
    localparam logic [2:0] ACT_UNDEF5 = 3'd5;
    localparam logic [2:0] ACT_UNDEF6 = 3'd6;
    localparam logic [2:0] ACT_UNDEF7 = 3'd7;

    typedef struct {
        logic [2:0] act;
        logic       sym;
        logic [2:0] tgt;
        bit         hold;   // wait for all results before sending this one
    } req_t;

    typedef struct {
        logic [2:0] cur;
        logic [7:0] reach;
        logic [7:0] garbage;
        logic [7:0] listed;
        logic [7:0] deleted;
        logic       ok;
    } fsm_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the automaton
    logic [2:0] succ [NSTATES][2];
    logic [2:0] cur_state;
    logic [7:0] reached;
    logic [7:0] listed;
    logic [7:0] purged;

    req_t        pending_reqs[$];
    fsm_result_t results_due[$];
    req_t        offered;
    int          accepted_cnt = 0;
    int          returned_cnt = 0;
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          drv_gap = 0;
    int          rdy_stall = 0;

    programmable_fsm_with_reachability_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    task automatic reset_shadow();
        succ = '{'{3'd7, 3'd6}, '{3'd4, 3'd7}, '{3'd5, 3'd3}, '{3'd1, 3'd4},
                 '{3'd6, 3'd5}, '{3'd3, 3'd0}, '{3'd0, 3'd1}, '{3'd7, 3'd2}};
        cur_state = 3'd0;
        reached = 8'h00;
        listed = 8'h00;
        purged = 8'h00;
    endtask

    function automatic fsm_result_t apply_request(req_t rq);
        fsm_result_t res;
        logic [7:0]  r;
        logic [7:0]  add;
        logic [7:0]  hits;
        logic [7:0]  fresh;
        int          s;
        int          k;
        res.garbage = 8'h00;
        res.ok = 1'b0;
        case (rq.act)
            ACT_STEP: cur_state = succ[cur_state][rq.sym];
            ACT_REWRITE: begin
                if (!purged[rq.tgt]) begin
                    succ[cur_state][rq.sym] = rq.tgt;
                    res.ok = 1'b1;
                end
            end
            ACT_FIND: begin
                // a deleted start state reaches nothing, not even itself
                r = purged[cur_state] ? 8'h00 : (8'h01 << cur_state);
                for (k = 0; k < NSTATES; k++) begin
                    add = 8'h00;
                    for (s = 0; s < NSTATES; s++)
                        if (r[s])
                            add = add | (8'h01 << succ[s][0]) | (8'h01 << succ[s][1]);
                    r = r | (add & ~purged);
                end
                reached = r;
                res.garbage = ~r & ~purged;
                listed = listed | res.garbage;
            end
            ACT_PURGE: begin
                // edges out of deleted states still count as targets
                hits = 8'h00;
                for (s = 0; s < NSTATES; s++)
                    hits = hits | (8'h01 << succ[s][0]) | (8'h01 << succ[s][1]);
                fresh = hits & listed & ~purged;
                purged = purged | fresh;
                res.ok = (fresh != 8'h00);
            end
            ACT_QUERY: res.ok = listed[rq.tgt];
            default: ;
        endcase
        res.cur = cur_state;
        res.reach = reached;
        res.listed = listed;
        res.deleted = purged;
        return res;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_req(logic [2:0] act, logic sym, logic [2:0] tgt, bit hold = 0);
        req_t rq;
        rq.act = act;
        rq.sym = sym;
        rq.tgt = tgt;
        rq.hold = hold;
        pending_reqs.push_back(rq);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin : driver
        req_t nxt;
        bit   quiet;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            quiet = (accepted_cnt >= 400 && accepted_cnt < 600);
            if (s_tvalid && s_tready) begin
                results_due.push_back(apply_request(offered));
                accepted_cnt++;
                if (!quiet && $urandom_range(0, 99) < 35)
                    drv_gap = idle_len();
            end
            if (s_tvalid && !s_tready) begin
                // request still on the bus, hold it
            end else if (drv_gap > 0) begin
                drv_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].hold && results_due.size() != 0)) begin
                nxt = pending_reqs.pop_front();
                offered = nxt;
                s_tdata <= {1'b0, nxt.tgt, nxt.sym, nxt.act};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and ready generation
    always @(posedge aclk) begin : monitor
        fsm_result_t got;
        fsm_result_t want;
        bit          quiet;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            quiet = (returned_cnt >= 900 && returned_cnt < 1100);
            if (m_tvalid && m_tready) begin
                returned_cnt++;
                got.cur = m_tdata[2:0];
                got.reach = m_tdata[10:3];
                got.garbage = m_tdata[18:11];
                got.listed = m_tdata[26:19];
                got.deleted = m_tdata[34:27];
                got.ok = m_tdata[35];
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("current_state", 8'(want.cur), 8'(got.cur));
                    check_field("reachable_mask", want.reach, got.reach);
                    check_field("garbage_mask", want.garbage, got.garbage);
                    check_field("listed_mask", want.listed, got.listed);
                    check_field("deleted_flags", want.deleted, got.deleted);
                    check_field("ok", 8'(want.ok), 8'(got.ok));
                end
            end
            if (rdy_stall > 0) begin
                rdy_stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 30) begin
                rdy_stall = idle_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int          n;
        int          w;
        int          purge_w;
        int          total;
        logic [2:0]  act;
        reset_shadow();

        // directed: cut C and H off, delete them, then walk into deleted states
        add_req(ACT_QUERY, 1'b0, 3'd7);
        add_req(ACT_QUERY, 1'b1, 3'd0);
        add_req(ACT_REWRITE, 1'b0, 3'd0);     // A loops to itself on 0
        add_req(ACT_STEP, 1'b1, 3'd0);        // A -> G
        add_req(ACT_STEP, 1'b1, 3'd7);        // G -> B
        add_req(ACT_REWRITE, 1'b1, 3'd1);     // B loops to itself on 1
        add_req(ACT_FIND, 1'b0, 3'd0);        // C and H unreachable
        add_req(ACT_QUERY, 1'b0, 3'd2);
        add_req(ACT_REWRITE, 1'b0, 3'd7);     // B points at listed H
        add_req(ACT_PURGE, 1'b1, 3'd7);
        add_req(ACT_PURGE, 1'b0, 3'd0);       // nothing new to delete
        add_req(ACT_REWRITE, 1'b1, 3'd2);     // deleted target, refused
        add_req(ACT_STEP, 1'b0, 3'd0);        // into deleted H
        add_req(ACT_STEP, 1'b1, 3'd0);        // into deleted C
        add_req(ACT_FIND, 1'b1, 3'd7);        // sweep from a deleted state
        add_req(ACT_UNDEF5, 1'b1, 3'd7);
        add_req(ACT_UNDEF6, 1'b0, 3'd3);
        add_req(ACT_UNDEF7, 1'b0, 3'd0);
        add_req(ACT_STEP, 1'b0, 3'd0);
        add_req(ACT_REWRITE, 1'b1, 3'd0);
        add_req(ACT_QUERY, 1'b1, 3'd5);

        // random: purges stay rare for most of the run, since deletions never undo
        for (n = 0; n < RAND_REQS; n++) begin
            purge_w = (n < 1200) ? 3 : 60;
            w = $urandom_range(0, 999);
            if (w < purge_w)
                act = ACT_PURGE;
            else if (w < 320)
                act = ACT_STEP;
            else if (w < 620)
                act = ACT_REWRITE;
            else if (w < 770)
                act = ACT_FIND;
            else if (w < 890)
                act = ACT_QUERY;
            else if (w < 940)
                act = 3'($urandom_range(5, 7));
            else
                act = ACT_STEP;
            add_req(act, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    (n == 700 || n == 1300));
        end
        total = pending_reqs.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt != total)
            @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### programmable_fsm_with_reachability_core.f
+incdir+hw/rtl
hw/rtl/pfsm_pkg.sv
hw/rtl/pfsm_ctrl.sv
hw/rtl/pfsm_datapath.sv
hw/rtl/programmable_fsm_with_reachability_core.sv
tb/tb.sv
